/* rtl/modem_clock_reply_to_epoch_defines.svh */
`ifndef MODEM_CLOCK_REPLY_TO_EPOCH_DEFINES_SVH
`define MODEM_CLOCK_REPLY_TO_EPOCH_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define MCRE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked only out of reset.
`define MCRE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/mcre_pkg.sv */
`default_nettype none

package mcre_pkg;

   // Transaction payloads
   localparam int EPOCH_W = 42;

   typedef struct packed {
      logic [7:0] reply_byte;
      logic       end_of_reply;
   } req_type;

   typedef struct packed {
      logic               parse_ok;
      logic [EPOCH_W-1:0] epoch_seconds;
   } rsp_type;

   // Stamp fields, in stamp order
   localparam int FIELD_COUNT = 6;
   localparam int FIELD_W     = 7;
   localparam int FLD_YEAR    = 0;
   localparam int FLD_MONTH   = 1;
   localparam int FLD_DAY     = 2;
   localparam int FLD_HOUR    = 3;
   localparam int FLD_MINUTE  = 4;
   localparam int FLD_SECOND  = 5;

   localparam int                  OFFSET_W   = 10;
   localparam logic [OFFSET_W-1:0] OFFSET_MAX = 10'd999;

   // One parsed reply, handed from the parser to the epoch unit
   typedef struct packed {
      logic                                  ok;
      logic [FIELD_COUNT-1:0][FIELD_W-1:0]   fields;
      logic [OFFSET_W-1:0]                   offset;
      logic                                  offset_sub;
   } job_type;

   // Job queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic nonempty;
      logic full;
   } queue_status_type;

   // Parser scan phase
   typedef enum logic [1:0] {
      PH_PREFIX,
      PH_QUOTE,
      PH_STAMP,
      PH_DONE
   } phase_type;

   // Epoch unit sequencer
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SPLIT,
      BK_DAYS,
      BK_MUL,
      BK_SUM
   } back_state_type;

endpackage

`default_nettype wire

/* rtl/mcre_front.sv */
`default_nettype none

module mcre_front import mcre_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire req_type          req,
   input  wire queue_status_type q_status,
   output logic                  push,
   output job_type               push_job
);

   localparam logic [2:0] PREFIX_LEN    = 3'd6;
   localparam logic [4:0] POS_MAX       = 5'd31;
   localparam logic [4:0] MIN_STAMP_LEN = 5'd17;
   localparam int         OFFSET_WIDE_W = OFFSET_W + 4;
   localparam logic [7:0] CHAR_QUOTE    = 8'h22;
   localparam logic [7:0] CHAR_PLUS     = 8'h2B;
   localparam logic [7:0] CHAR_MINUS    = 8'h2D;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_NINE     = 8'h39;

   // "+CCLK:"
   function automatic logic [7:0] prefix_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = CHAR_PLUS;
         3'd1:    ch = 8'h43;
         3'd2:    ch = 8'h43;
         3'd3:    ch = 8'h4C;
         3'd4:    ch = 8'h4B;
         3'd5:    ch = 8'h3A;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic is_digit(input logic [7:0] ch);
      return ch inside {[CHAR_ZERO:CHAR_NINE]};
   endfunction

   function automatic logic [OFFSET_W-1:0] offset_step(input logic [OFFSET_W-1:0] val,
                                                       input logic [3:0] dig);
      logic [OFFSET_WIDE_W-1:0] wide;
      wide = OFFSET_WIDE_W'(val) * OFFSET_WIDE_W'(10) + OFFSET_WIDE_W'(dig);
      return (wide > OFFSET_WIDE_W'(OFFSET_MAX)) ? OFFSET_MAX : wide[OFFSET_W-1:0];
   endfunction

   phase_type                          phase_ff, phase_in;
   logic [2:0]                         match_ff, match_in;
   logic [4:0]                         pos_ff, pos_in;
   logic [FIELD_COUNT-1:0][FIELD_W-1:0] fld_ff, fld_in;
   logic [FIELD_COUNT-1:0]             stop_ff, stop_in;
   logic                               plus_seen_ff, plus_seen_in;
   logic [OFFSET_W-1:0]                pval_ff, pval_in;
   logic                               pstop_ff, pstop_in;
   logic [OFFSET_W-1:0]                mval_ff, mval_in;
   logic                               mstop_ff, mstop_in;
   logic                               accept;
   logic [7:0]                         ch;
   logic [3:0]                         dig;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;
   assign ch        = req.reply_byte;
   assign dig       = req.reply_byte[3:0];

   always_comb begin
      phase_in     = phase_ff;
      match_in     = match_ff;
      pos_in       = pos_ff;
      fld_in       = fld_ff;
      stop_in      = stop_ff;
      plus_seen_in = plus_seen_ff;
      pval_in      = pval_ff;
      pstop_in     = pstop_ff;
      mval_in      = mval_ff;
      mstop_in     = mstop_ff;
      push         = 1'b0;
      push_job     = '0;
      if (accept) begin
         case (phase_ff)
            PH_PREFIX: begin
               if (match_ff < PREFIX_LEN && ch == prefix_char(match_ff)) begin
                  match_in = match_ff + 3'd1;
               end else begin
                  match_in = (ch == CHAR_PLUS) ? 3'd1 : 3'd0;
               end
               if (match_in >= PREFIX_LEN) begin
                  phase_in = PH_QUOTE;
               end
            end
            PH_QUOTE: begin
               // offsets stay at zero until a sign shows up in the stamp
               if (ch == CHAR_QUOTE) begin
                  phase_in = PH_STAMP;
                  pstop_in = 1'b1;
                  mstop_in = 1'b1;
               end
            end
            PH_STAMP: begin
               if (ch == CHAR_QUOTE) begin
                  phase_in = PH_DONE;
               end else begin
                  // two character slots per field, separator in between
                  for (int k = 0; k < FIELD_COUNT; k++) begin
                     if ((pos_ff == 5'(3 * k) || pos_ff == 5'(3 * k + 1)) && !stop_ff[k]) begin
                        if (is_digit(ch)) begin
                           fld_in[k] = FIELD_W'(fld_ff[k]) * FIELD_W'(10) + FIELD_W'(dig);
                        end else begin
                           stop_in[k] = 1'b1;
                        end
                     end
                  end
                  if (ch == CHAR_PLUS) begin
                     plus_seen_in = 1'b1;
                     pval_in      = '0;
                     pstop_in     = 1'b0;
                  end else if (!pstop_ff) begin
                     if (is_digit(ch)) begin
                        pval_in = offset_step(pval_ff, dig);
                     end else begin
                        pstop_in = 1'b1;
                     end
                  end
                  if (ch == CHAR_MINUS) begin
                     mval_in  = '0;
                     mstop_in = 1'b0;
                  end else if (!mstop_ff) begin
                     if (is_digit(ch)) begin
                        mval_in = offset_step(mval_ff, dig);
                     end else begin
                        mstop_in = 1'b1;
                     end
                  end
                  if (pos_ff != POS_MAX) begin
                     pos_in = pos_ff + 5'd1;
                  end
               end
            end
            default: begin
            end
         endcase

         if (req.end_of_reply) begin
            push                = 1'b1;
            push_job.ok         = (phase_in == PH_DONE) && (pos_in >= MIN_STAMP_LEN);
            push_job.fields     = fld_in;
            push_job.offset     = plus_seen_in ? pval_in : mval_in;
            push_job.offset_sub = plus_seen_in;
            // start over for the next reply
            phase_in     = PH_PREFIX;
            match_in     = '0;
            pos_in       = '0;
            fld_in       = '0;
            stop_in      = '0;
            plus_seen_in = 1'b0;
            pval_in      = '0;
            pstop_in     = 1'b0;
            mval_in      = '0;
            mstop_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_PREFIX;
         match_ff     <= '0;
         pos_ff       <= '0;
         fld_ff       <= '0;
         stop_ff      <= '0;
         plus_seen_ff <= 1'b0;
         pval_ff      <= '0;
         pstop_ff     <= 1'b0;
         mval_ff      <= '0;
         mstop_ff     <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         match_ff     <= match_in;
         pos_ff       <= pos_in;
         fld_ff       <= fld_in;
         stop_ff      <= stop_in;
         plus_seen_ff <= plus_seen_in;
         pval_ff      <= pval_in;
         pstop_ff     <= pstop_in;
         mval_ff      <= mval_in;
         mstop_ff     <= mstop_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/mcre_queue.sv */
`default_nettype none

module mcre_queue import mcre_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output job_type      pop_job,
   output queue_status_type status
);

   job_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] ptr);
      return (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + QPTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   assign pop_job         = slot_ff[rd_ptr_ff];
   assign status.nonempty = (count_ff != '0);
   assign status.full     = (count_ff == QCNT_W'(QUEUE_DEPTH));

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/mcre_back.sv */
`default_nettype none

module mcre_back import mcre_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire queue_status_type q_status,
   input  wire job_type          q_job,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp
);

   localparam int YEAR_W   = 7;    // years after 1999
   localparam int DAYS_W   = 16;
   localparam int DSEC_W   = 33;
   localparam int TOD_W    = 19;
   localparam int OFFSEC_W = 20;
   localparam int LOCAL_W  = 34;
   localparam int RES_W    = 35;
   localparam int RECIP_W  = 13;

   localparam logic [DAYS_W-1:0]   DAYS_TO_1999  = 16'd10592;
   localparam logic [DAYS_W:0]     DAYS_PER_YEAR = 17'd365;
   localparam logic [YEAR_W-1:0]   YB_2100       = 7'd101;
   localparam logic [YEAR_W-1:0]   YB_AFTER_2100 = 7'd102;
   localparam logic [3:0]          MONTH_DEC     = 4'd11;
   localparam logic [3:0]          MONTH_MAR     = 4'd2;
   localparam logic [RECIP_W-1:0]  RECIP_12      = 13'd43;   // x/12 = (x*43)>>9 for x < 128
   localparam int                  RECIP_SHIFT   = 9;
   localparam logic [DSEC_W-1:0]   SEC_PER_DAY   = 33'd86400;
   localparam logic [TOD_W-1:0]    SEC_PER_HOUR  = 19'd3600;
   localparam logic [TOD_W-1:0]    SEC_PER_MIN   = 19'd60;
   localparam logic [OFFSEC_W-1:0] SEC_PER_QTR   = 20'd900;

   // days from January 1 to the first of month m (0 = January), common year
   function automatic logic [8:0] month_start(input logic [3:0] m);
      logic [8:0] d;
      case (m)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd59;
         4'd3:    d = 9'd90;
         4'd4:    d = 9'd120;
         4'd5:    d = 9'd151;
         4'd6:    d = 9'd181;
         4'd7:    d = 9'd212;
         4'd8:    d = 9'd243;
         4'd9:    d = 9'd273;
         4'd10:   d = 9'd304;
         4'd11:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

   back_state_type        state_ff, state_in;
   job_type               job_ff, job_in;
   logic [YEAR_W-1:0]     yb_ff, yb_in;
   logic [3:0]            mon_ff, mon_in;
   logic                  leap_ff, leap_in;
   logic [DAYS_W-1:0]     days_ff, days_in;
   logic [DSEC_W-1:0]     dsec_ff, dsec_in;
   logic [TOD_W-1:0]      tod_ff, tod_in;
   logic [OFFSEC_W-1:0]   offsec_ff, offsec_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [FIELD_W-1:0]    mon_m1;
   logic [RECIP_W-1:0]    recip_prod;
   logic [3:0]            year_carry;
   logic [FIELD_W-1:0]    mon_rem;
   logic [YEAR_W-1:0]     leap_count;
   logic [DAYS_W:0]       day_sum;
   logic [LOCAL_W-1:0]    local_sec;
   logic [RES_W-1:0]      utc_sec;
   logic                  out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // month split: month 0 is the prior December; months above 12 fold into later years
   always_comb begin
      mon_m1     = job_ff.fields[FLD_MONTH] - FIELD_W'(1);
      recip_prod = RECIP_W'(mon_m1) * RECIP_12;
      year_carry = recip_prod[RECIP_SHIFT +: 4];
      mon_rem    = mon_m1 - FIELD_W'(year_carry) * FIELD_W'(12);
      if (job_ff.fields[FLD_MONTH] == '0) begin
         yb_in  = YEAR_W'(job_ff.fields[FLD_YEAR]);
         mon_in = MONTH_DEC;
      end else begin
         yb_in  = YEAR_W'(job_ff.fields[FLD_YEAR]) + YEAR_W'(1) + YEAR_W'(year_carry);
         mon_in = mon_rem[3:0];
      end
      // 2000 is leap, 2100 is not
      leap_in = (yb_in[1:0] == 2'b01) && (yb_in != YB_2100);
   end

   // day count from 1970 to the stamp's date
   always_comb begin
      leap_count = (yb_ff + YEAR_W'(2)) >> 2;
      if (yb_ff >= YB_AFTER_2100) begin
         leap_count = leap_count - YEAR_W'(1);
      end
      day_sum = (DAYS_W+1)'(DAYS_TO_1999)
              + (DAYS_W+1)'(yb_ff) * DAYS_PER_YEAR
              + (DAYS_W+1)'(leap_count)
              + (DAYS_W+1)'(month_start(mon_ff))
              + (DAYS_W+1)'(leap_ff && (mon_ff >= MONTH_MAR))
              + (DAYS_W+1)'(job_ff.fields[FLD_DAY])
              - (DAYS_W+1)'(1);
      days_in = day_sum[DAYS_W-1:0];
   end

   always_comb begin
      dsec_in   = DSEC_W'(days_ff) * SEC_PER_DAY;
      tod_in    = TOD_W'(job_ff.fields[FLD_HOUR]) * SEC_PER_HOUR
                + TOD_W'(job_ff.fields[FLD_MINUTE]) * SEC_PER_MIN
                + TOD_W'(job_ff.fields[FLD_SECOND]);
      offsec_in = OFFSEC_W'(job_ff.offset) * SEC_PER_QTR;
   end

   // local time to UTC, clamped at zero
   always_comb begin
      local_sec = LOCAL_W'(dsec_ff) + LOCAL_W'(tod_ff);
      if (job_ff.offset_sub) begin
         utc_sec = (LOCAL_W'(offsec_ff) < local_sec) ?
                   RES_W'(local_sec) - RES_W'(offsec_ff) : '0;
      end else begin
         utc_sec = RES_W'(local_sec) + RES_W'(offsec_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         BK_IDLE: begin
            if (q_status.nonempty) begin
               pop      = 1'b1;
               job_in   = q_job;
               state_in = BK_SPLIT;
            end
         end
         BK_SPLIT: state_in = BK_DAYS;
         BK_DAYS:  state_in = BK_MUL;
         BK_MUL:   state_in = BK_SUM;
         BK_SUM: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in.parse_ok = job_ff.ok && (local_sec != '0);
               rsp_in.epoch_seconds = (job_ff.ok && (local_sec != '0)) ?
                                      EPOCH_W'(utc_sec) : '0;
               state_in        = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      yb_ff     <= yb_in;
      mon_ff    <= mon_in;
      leap_ff   <= leap_in;
      days_ff   <= days_in;
      dsec_ff   <= dsec_in;
      tod_ff    <= tod_in;
      offsec_ff <= offsec_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

/* rtl/modem_clock_reply_to_epoch.sv */
// Modem clock reply to UTC epoch.
// req channel: one reply character per transaction (req.reply_byte), with
// req.end_of_reply set on the last character. Characters are taken one per
// cycle; the parser looks for "+CCLK:", the opening quote and the stamp
// "yy/MM/dd,hh:mm:ss+zz", and packs what it found into a job on the last one.
// rsp channel: one transaction per reply, parse_ok plus UTC seconds since
// 1970 (zero on failure). Nothing comes out for characters that are not last.
// After the last character is taken, its job goes through the queue and then
// the epoch unit, which handles one reply at a time (queue pop, month split,
// day count, multiply, sum into the output register) before it pops the next.
// Throughput: one character per cycle while req_stall is low.
// A 2-entry job queue sits between parser and epoch unit, so req_stall rises
// only when two finished replies wait for the epoch unit.
// When the receiver stalls, the result holds in the output register; the
// epoch unit and then the queue fill behind it.
// Reset (synchronous) clears the parser state, empties the queue and drops
// rsp_valid. Nothing needs a clearing pass afterwards.
`default_nettype none

`include "modem_clock_reply_to_epoch_defines.svh"

module modem_clock_reply_to_epoch import mcre_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp
);

   // parser to queue
   logic             push;
   job_type          push_job;
   // queue to epoch unit
   logic             pop;
   job_type          pop_job;
   queue_status_type q_status;

   // Front: prefix match, quote tracking, field and offset capture.
   mcre_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .q_status  (q_status),
      .push      (push),
      .push_job  (push_job)
   );

   // Short job queue, lets the parser keep taking characters while the
   // epoch unit is busy or the receiver stalls.
   mcre_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .status   (q_status)
   );

   // Back: calendar arithmetic and the output register.
   mcre_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_job     (pop_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   // A full queue must hold off the next character.
   `MCRE_ASSERT_NOW(a_full_stalls, q_status.full, req_stall, "queue full but req not stalled")

   // A job leaves the queue only when one is there.
   `MCRE_ASSERT_NOW(a_pop_nonempty, pop, q_status.nonempty, "pop from empty job queue")

   // The last character of a reply always lands a job in the queue.
   `MCRE_ASSERT_NEXT(a_push_lands, push, q_status.nonempty, "pushed job missing from queue")

   // A failed parse never reports a time.
   `MCRE_ASSERT_NOW(a_fail_zero, rsp_valid && !rsp.parse_ok, rsp.epoch_seconds == '0,
                    "failed parse with nonzero epoch")

endmodule

`default_nettype wire

/* sim/tb_modem_clock_reply_to_epoch.sv */
module tb_modem_clock_reply_to_epoch;
   import mcre_pkg::*;

   // Character codes the parser reacts to
   localparam byte unsigned CH_ZERO  = "0";
   localparam byte unsigned CH_NINE  = "9";
   localparam byte unsigned CH_PLUS  = "+";
   localparam byte unsigned CH_MINUS = "-";
   localparam byte unsigned CH_QUOTE = 8'h22;

   localparam int TAG_LEN    = 6;      // length of "+CCLK:"
   localparam int MIN_STAMP  = 17;     // shortest stamp that parses
   localparam int STAMP_SAT  = 31;     // stamp length counter saturates here
   localparam int QUARTER_HR = 15 * 60;

   localparam int RANDOM_CHARS  = 170;  // random characters to offer
   localparam int RANDOM_MIN_RX = 6;    // and at least this many random replies
   localparam int HOLD_CYCLES   = 300;  // long receiver hold-off
   localparam int SETTLE_CYCLES = 12;   // extra wait after the final drain
   localparam int IDLE_LIMIT    = 2000; // cycles with no transaction at all

   // Receiver stall behaviors
   localparam int RX_OPEN    = 0;
   localparam int RX_CHOPPY  = 1;
   localparam int RX_CLOGGED = 2;

   typedef enum int {
      FLAW_NONE,
      FLAW_PREFIX,
      FLAW_OPEN,
      FLAW_CLOSE,
      FLAW_SHORT
   } flaw_type;

   // ------------------------------------------------------------------
   // Scoreboard: tracks the parser state per character and queues the
   // epoch expected for every reply end.
   // ------------------------------------------------------------------
   class reply_epoch_board;
      phase_type   phase;
      int          tag_len;
      int          stamp_len;
      int          fld [FIELD_COUNT];
      bit          fld_stop [FIELD_COUNT];
      bit          plus_seen;
      int          plus_off;
      bit          plus_stop;
      int          minus_off;
      bit          minus_stop;
      rsp_type     epoch_q [$];
      int unsigned faults;
      int unsigned results;
      int unsigned parsed_ok;
      string       tag = "+CCLK:";

      function new();
         clear();
      endfunction

      function void clear();
         phase     = PH_PREFIX;
         tag_len   = 0;
         stamp_len = 0;
         foreach (fld[k]) begin
            fld[k]      = 0;
            fld_stop[k] = 1'b0;
         end
         plus_seen  = 1'b0;
         plus_off   = 0;
         plus_stop  = 1'b0;
         minus_off  = 0;
         minus_stop = 1'b0;
      endfunction

      function bit is_digit(byte unsigned c);
         return c >= CH_ZERO && c <= CH_NINE;
      endfunction

      // leading digits after a sign, saturating
      function void offset_digit(input byte unsigned c, inout int v, inout bit stop);
         if (stop)
            return;
         if (!is_digit(c)) begin
            stop = 1'b1;
            return;
         end
         v = v * 10 + int'(c - CH_ZERO);
         if (v > int'(OFFSET_MAX))
            v = int'(OFFSET_MAX);
      endfunction

      function void stamp_char(byte unsigned c);
         int k;
         if (stamp_len < MIN_STAMP && stamp_len % 3 < 2) begin
            k = stamp_len / 3;
            if (!fld_stop[k]) begin
               if (is_digit(c))
                  fld[k] = fld[k] * 10 + int'(c - CH_ZERO);
               else
                  fld_stop[k] = 1'b1;
            end
         end
         if (c == CH_PLUS) begin
            plus_seen = 1'b1;
            plus_off  = 0;
            plus_stop = 1'b0;
         end else begin
            offset_digit(c, plus_off, plus_stop);
         end
         if (c == CH_MINUS) begin
            minus_off  = 0;
            minus_stop = 1'b0;
         end else begin
            offset_digit(c, minus_off, minus_stop);
         end
         if (stamp_len < STAMP_SAT)
            stamp_len++;
      endfunction

      // days from 1970-01-01 to the first of month m (1..12) of year y
      function longint days_from_civil(longint y, longint m);
         longint era, yoe, doy, doe;
         if (m <= 2)
            y = y - 1;
         era = y / 400;
         yoe = y - era * 400;
         doy = (153 * (m + (m > 2 ? -3 : 9)) + 2) / 5;
         doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
         return era * 146097 + doe - 719468;
      endfunction

      function rsp_type reply_result();
         rsp_type r;
         longint  year, mon, secs;
         r = '0;
         if (phase == PH_DONE && stamp_len >= MIN_STAMP) begin
            year = 2000 + fld[FLD_YEAR];
            mon  = longint'(fld[FLD_MONTH]) - 1;
            // month 0 and months past 12 roll into neighboring years
            if (mon < 0) begin
               mon  = mon + 12;
               year = year - 1;
            end else begin
               year = year + mon / 12;
               mon  = mon % 12;
            end
            secs = days_from_civil(year, mon + 1) + fld[FLD_DAY] - 1;
            secs = secs * 86400 + fld[FLD_HOUR] * 3600 + fld[FLD_MINUTE] * 60
                 + fld[FLD_SECOND];
            if (secs > 0) begin
               if (plus_seen)
                  secs = secs - plus_off * QUARTER_HR;
               else
                  secs = secs + minus_off * QUARTER_HR;
               r.parse_ok      = 1'b1;
               r.epoch_seconds = (secs > 0) ? secs[EPOCH_W-1:0] : '0;
            end
         end
         return r;
      endfunction

      function void take_char(req_type t);
         byte unsigned c;
         c = t.reply_byte;
         case (phase)
            PH_PREFIX: begin
               if (tag_len < TAG_LEN && c == tag[tag_len])
                  tag_len++;
               else
                  tag_len = (c == CH_PLUS) ? 1 : 0;
               if (tag_len >= TAG_LEN)
                  phase = PH_QUOTE;
            end
            PH_QUOTE: begin
               if (c == CH_QUOTE) begin
                  phase      = PH_STAMP;
                  plus_stop  = 1'b1;
                  minus_stop = 1'b1;
               end
            end
            PH_STAMP: begin
               if (c == CH_QUOTE)
                  phase = PH_DONE;
               else
                  stamp_char(c);
            end
            default: ;
         endcase
         if (t.end_of_reply) begin
            epoch_q.push_back(reply_result());
            clear();
         end
      endfunction

      function void complain(string msg);
         faults++;
         if (faults <= 10)
            $display("%0t mismatch: %s", $time, msg);
      endfunction

      function void match_result(rsp_type got);
         rsp_type want;
         results++;
         if (epoch_q.size() == 0) begin
            complain($sformatf("unexpected result parse_ok=%0b epoch_seconds=%0d",
                               got.parse_ok, got.epoch_seconds));
            return;
         end
         want = epoch_q.pop_front();
         if (want.parse_ok)
            parsed_ok++;
         if (got.parse_ok !== want.parse_ok)
            complain($sformatf("parse_ok expected %0b got %0b", want.parse_ok, got.parse_ok));
         else if (got.epoch_seconds !== want.epoch_seconds)
            complain($sformatf("epoch_seconds expected %0d got %0d",
                               want.epoch_seconds, got.epoch_seconds));
      endfunction

      function int pending();
         return epoch_q.size();
      endfunction
   endclass

   // ------------------------------------------------------------------
   // DUT and its signals; every input has a known value from time 0
   // ------------------------------------------------------------------
   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req       = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;

   modem_clock_reply_to_epoch dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   reply_epoch_board board;

   byte unsigned line_q [$];   // reply text being assembled
   int unsigned  chars_sent;
   int unsigned  replies_sent;
   int unsigned  burst_left;
   bit           hold_request;

   initial begin
      forever #2 clock = ~clock;
   end

   // Monitor: both channels sampled at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            board.take_char(req);
         if (rsp_valid && !rsp_stall)
            board.match_result(rsp);
      end
   end

   // Watchdog: any stretch without a single transaction ends the run
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle = 0;
         else
            idle++;
      end
      $display("timeout after %0d idle cycles", IDLE_LIMIT);
      $display("FAIL modem_clock_reply_to_epoch");
      $finish;
   end

   // Receiver: cycles through stall behaviors; a hold request forces a
   // long stall so the job queue fills and req_stall rises.
   initial begin : receiver
      int hold_left;
      int mode_left;
      int rx_mode;
      hold_left = 0;
      mode_left = 0;
      rx_mode   = RX_OPEN;
      forever begin
         @(negedge clock);
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            rsp_stall   <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               rx_mode   = $urandom_range(RX_OPEN, RX_CLOGGED);
               mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            case (rx_mode)
               RX_CHOPPY:  rsp_stall <= ($urandom_range(0, 99) < 35);
               RX_CLOGGED: rsp_stall <= ($urandom_range(0, 9) < 8);
               default:    rsp_stall <= 1'b0;
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // Sender. Called at a falling edge; returns at the falling edge after
   // the transaction was taken. Bursts of random length, random gaps.
   // ------------------------------------------------------------------
   task automatic send_char(input logic [7:0] b, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req       <= '{reply_byte: b, end_of_reply: last};
      do @(posedge clock); while (req_stall);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic ship_line();
      for (int i = 0; i < line_q.size(); i++)
         send_char(line_q[i], i == line_q.size() - 1);
      line_q.delete();
      replies_sent++;
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++)
         line_q.push_back(s[i]);
   endtask

   // mostly digits, now and then any byte (a quote ends the stamp early)
   function automatic byte unsigned field_char();
      if ($urandom_range(0, 9) != 0)
         return CH_ZERO + $urandom_range(0, 9);
      return $urandom_range(0, 255);
   endfunction

   task automatic put_offset(input byte unsigned sign);
      line_q.push_back(sign);
      repeat ($urandom_range(0, 4))
         line_q.push_back(CH_ZERO + $urandom_range(0, 9));
   endtask

   task automatic put_stamp();
      string seps = "//,::";
      for (int k = 0; k < FIELD_COUNT; k++) begin
         repeat (2) line_q.push_back(field_char());
         if (k < FIELD_COUNT - 1)
            line_q.push_back(($urandom_range(0, 19) == 0) ? field_char() : seps[k]);
      end
      case ($urandom_range(0, 5))
         0: ;
         1, 2: put_offset(CH_PLUS);
         3: put_offset(CH_MINUS);
         4: begin
            put_offset(CH_PLUS);
            put_offset(CH_MINUS);
         end
         default: begin
            put_offset(CH_MINUS);
            put_offset(CH_PLUS);
         end
      endcase
   endtask

   // One "+CCLK:" reply with random content and an optional defect
   task automatic put_reply(input flaw_type flaw);
      int base;
      int keep;
      repeat ($urandom_range(0, 4))
         line_q.push_back($urandom_range(0, 255));
      put_text(flaw == FLAW_PREFIX ? "+CCLX:" : "+CCLK:");
      if ($urandom_range(0, 1))
         put_text(" ");
      if (flaw != FLAW_OPEN)
         line_q.push_back(CH_QUOTE);
      base = line_q.size();
      put_stamp();
      if (flaw == FLAW_SHORT) begin
         keep = base + $urandom_range(0, MIN_STAMP - 1);
         while (line_q.size() > keep)
            void'(line_q.pop_back());
      end
      if (flaw != FLAW_CLOSE)
         line_q.push_back(CH_QUOTE);
      case ($urandom_range(0, 3))
         0: ;
         1: put_text("\r\n");
         2: put_text("\r\nOK\r\n");
         default: repeat ($urandom_range(1, 4)) line_q.push_back($urandom_range(0, 255));
      endcase
      ship_line();
   endtask

   task automatic put_noise(input int max_len);
      repeat ($urandom_range(1, max_len))
         line_q.push_back($urandom_range(0, 255));
      ship_line();
   endtask

   // Stop offering and wait for every outstanding result
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      int random_base;
      int n;
      int pick;
      board        = new();
      chars_sent   = 0;
      replies_sent = 0;
      burst_left   = 0;
      hold_request = 1'b0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: plain replies, both offset signs, month/day edges,
      // saturated offset, junk in fields, and each way a reply can fail.
      put_text("+CCLK: \"24/03/15,12:34:56+32\"\r\nOK");
      ship_line();
      put_text("AT+CCLK?\r\n+CCLK: \"99/12/31,23:59:59-48\"");
      ship_line();
      put_text("+CCLK: \"00/00/00,00:00:00\"");               // month 0, day 0, no sign
      ship_line();
      put_text("+CCLK: \"07/99/99,99:99:99+9999\"");           // month past 12, offset cap
      ship_line();
      put_text("+CCLK: \"24/1a/ 5,1:2x:-3+08-04+12\"");        // non-digits, several signs
      ship_line();
      put_text("+CCLK: \"24/01/01,00:00:0-\"");                // sign with no digits
      ship_line();
      put_text("+CCLK: \"24/01/01,00:00:00-0+\"");             // trailing plus wins
      ship_line();
      put_text("no prefix \"24/01/01,00:00:00+00\"");
      ship_line();
      put_text("+CCLK: 24/01/01,00:00:00+00");                 // no opening quote
      ship_line();
      put_text("+CCLK: \"24/01/01,00:00:00+00");               // no closing quote
      ship_line();
      put_text("+CCLK: \"24/01/01,00:00:0\"");                 // one char short
      ship_line();
      put_text("++CC+CCLK:\"20/02/29,12:00:00+00 trailing text well past the cap\"");
      ship_line();
      put_text("+CCLK:\"\"\"");                                // empty stamp
      ship_line();
      line_q.push_back(8'h00);
      line_q.push_back(8'hFF);
      ship_line();

      drain();

      // Random: mostly well-formed replies, some broken, some noise
      random_base = chars_sent;
      n = 0;
      while (chars_sent - random_base < RANDOM_CHARS || n < RANDOM_MIN_RX) begin
         if (n == 2) begin
            // receiver holds off while short replies keep coming
            hold_request = 1'b1;
            repeat (14) put_noise(3);
         end
         if (n == 4)
            drain();
         pick = $urandom_range(0, 99);
         if (pick < 65)
            put_reply(FLAW_NONE);
         else if (pick < 85)
            put_reply(flaw_type'($urandom_range(FLAW_PREFIX, FLAW_SHORT)));
         else
            put_noise(8);
         n++;
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run covered %0d replies (%0d characters): %0d results, %0d parsed ok",
               replies_sent, chars_sent, board.results, board.parsed_ok);
      $display("mismatches: %0d", board.faults);
      if (board.faults == 0)
         $display("PASS modem_clock_reply_to_epoch");
      else
         $display("FAIL modem_clock_reply_to_epoch");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/mcre_pkg.sv
rtl/mcre_front.sv
rtl/mcre_queue.sv
rtl/mcre_back.sv
rtl/modem_clock_reply_to_epoch.sv
sim/tb_modem_clock_reply_to_epoch.sv
